>>> design/group_signature_sorter_unit_assert.svh
// assertion macros for the group signature sorter
`ifndef GROUP_SIGNATURE_SORTER_UNIT_ASSERT_SVH
`define GROUP_SIGNATURE_SORTER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define GSS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define GSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define GSS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define GSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

>>> design/gss_pkg.sv
// shared constants and types of the group signature sorter
`default_nettype none
package gss_pkg;
    localparam int MAX_SIG_WORDS_DEF = 64;
    localparam int MAX_GROUP_DEF     = 16;

    localparam int          SW_REG_W       = 7;
    localparam int          GS_REG_W       = 5;
    localparam int          CFG_DATA_W     = 7;
    localparam int          CFG_IDX_W      = 2;
    localparam logic [6:0]  SIG_WORDS_RST  = 7'd16;
    localparam logic [4:0]  GROUP_SIZE_RST = 5'd16;

    localparam logic [1:0]  REG_SIG_WORDS  = 2'd0;
    localparam logic [1:0]  REG_GROUP_SIZE = 2'd1;

    localparam logic        FUNC_LOAD = 1'b0;
    localparam logic        FUNC_READ = 1'b1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INIT,
        CELL_INSERT,
        CELL_ROTATE
    } t_cell_op;
endpackage
`default_nettype wire

>>> design/group_signature_sorter_unit.sv
// top level of the group signature sorter: word store, rank chain and control
//
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | tdata = data_word, tuser = func
//  m_axis   | out       | tdata = sorted_word, tlast = group_end
//  cfg      | in        | index 0 = sig_words, index 1 = group_size
//
// a load word is written straight into the store; a read word goes through the
// registered store read, then the output register, and waits while m_axis stalls
// after the last load the group is sorted by insertion through the rank chain:
// each word compared is read from the store in S_CMP and compared in S_WAIT,
// and a key that moves down to the front is inserted from S_CMP; s_axis is not
// ready during the sort
// reset is synchronous, active low; the store needs no clearing
// the output register lets s_axis take an item while a result waits
`default_nettype none
`include "group_signature_sorter_unit_assert.svh"
module group_signature_sorter_unit #(
    parameter int MAX_SIG_WORDS = gss_pkg::MAX_SIG_WORDS_DEF,
    parameter int MAX_GROUP     = gss_pkg::MAX_GROUP_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [63:0]                     s_axis_tdata,  // data_word
    input  wire logic                            s_axis_tuser,  // func
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [63:0]                     m_axis_tdata,  // sorted_word
    output logic                                 m_axis_tlast,  // group_end
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [gss_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [gss_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import gss_pkg::*;

    localparam int SW_W  = $clog2(MAX_SIG_WORDS + 1);
    localparam int GS_W  = $clog2(MAX_GROUP + 1);
    localparam int SL_W  = $clog2(MAX_GROUP);
    localparam int TOT_W = SW_W + GS_W;
    localparam int DEPTH = MAX_SIG_WORDS * MAX_GROUP;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = SL_W + SW_W + 1;
    localparam int SCW   = (SW_W > SW_REG_W) ? SW_W : SW_REG_W;
    localparam int GCW   = (GS_W > GS_REG_W) ? GS_W : GS_REG_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_WAIT = 4'b0100,
        S_READ = 4'b1000
    } t_state;

    t_state               r_state;
    logic [SW_REG_W-1:0]  r_sig_words;
    logic [GS_REG_W-1:0]  r_group_size;
    logic                 r_emit;
    logic [TOT_W-1:0]     r_load_pos;
    logic [TOT_W-1:0]     r_read_pos;
    logic [SW_W-1:0]      r_rw;      // word within the signature being read
    logic [SW_W-1:0]      r_w;       // word under compare during the sort
    logic [SL_W-1:0]      r_i;       // slot being inserted (key)
    logic [SL_W-1:0]      r_j;       // candidate position of the key
    logic                 r_m_valid;
    logic [63:0]          r_m_data;
    logic                 r_m_last;
    logic [63:0]          r_store [DEPTH];
    logic [63:0]          r_rd_a;
    logic [63:0]          r_rd_b;

    logic [SL_W-1:0]      w_cell [MAX_GROUP];
    logic [SW_W-1:0]      eff_sw;
    logic [GS_W-1:0]      eff_gs;
    logic [TOT_W-1:0]     total;
    logic [SCW-1:0]       sw_ext;
    logic [GCW-1:0]       gs_ext;
    logic                 cfg_wr;
    logic                 in_acc;
    logic                 load_wr;
    logic                 load_done;
    logic                 w_last;
    logic                 rw_last;
    logic                 rd_last;
    logic                 out_free;
    logic                 cmp_gt;
    logic                 cmp_lt;
    logic                 do_insert;
    logic                 sort_last;
    logic [SL_W-1:0]      cell_sel;
    logic [PW-1:0]        prod_a;
    logic [PW-1:0]        prod_b;
    logic [AW-1:0]        addr_a;
    logic [AW-1:0]        addr_b;
    t_cell_op             cell_op;

    // clamp configuration into the meaningful range
    always_comb begin
        sw_ext = SCW'(r_sig_words);
        gs_ext = GCW'(r_group_size);
        if (sw_ext == '0) begin
            eff_sw = SW_W'(1);
        end else if (sw_ext > SCW'(MAX_SIG_WORDS)) begin
            eff_sw = SW_W'(MAX_SIG_WORDS);
        end else begin
            eff_sw = SW_W'(sw_ext);
        end
        if (gs_ext == '0) begin
            eff_gs = GS_W'(1);
        end else if (gs_ext > GCW'(MAX_GROUP)) begin
            eff_gs = GS_W'(MAX_GROUP);
        end else begin
            eff_gs = GS_W'(gs_ext);
        end
    end

    assign total = TOT_W'(eff_sw) * TOT_W'(eff_gs);

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign cfg_wr        = i_cfg_valid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign load_wr       = in_acc && (s_axis_tuser == FUNC_LOAD) && !r_emit;
    assign load_done     = load_wr && ((r_load_pos + 1'b1) >= total);

    assign w_last    = (SW_W'(r_w + 1'b1) == eff_sw);
    assign rw_last   = (SW_W'(r_rw + 1'b1) == eff_sw);
    assign rd_last   = ((r_read_pos + 1'b1) >= total);
    assign out_free  = !r_m_valid || m_axis_tready;
    assign sort_last = ((GS_W'(r_i) + 1'b1) == eff_gs);

    // compare of slot at j-1 against the key, word 0 most significant
    assign cmp_gt    = r_rd_a > r_rd_b;
    assign cmp_lt    = r_rd_a < r_rd_b;
    assign do_insert = ((r_state == S_CMP) && (r_j == '0)) ||
                       ((r_state == S_WAIT) && (cmp_lt || (!cmp_gt && w_last)));

    assign cell_sel = w_cell[r_j - 1'b1];

    // store addresses: slot * sig_words + word
    // the read address holds while a read waits for the output register
    always_comb begin
        if ((r_state == S_IDLE) || (r_state == S_READ)) begin
            prod_a = PW'(w_cell[0]) * PW'(eff_sw) + PW'(r_rw);
        end else begin
            prod_a = PW'(cell_sel) * PW'(eff_sw) + PW'(r_w);
        end
        prod_b = PW'(r_i) * PW'(eff_sw) + PW'(r_w);
        addr_a = prod_a[AW-1:0];
        addr_b = prod_b[AW-1:0];
    end

    always_comb begin
        if (load_done) begin
            cell_op = CELL_INIT;
        end else if (do_insert) begin
            cell_op = CELL_INSERT;
        end else if ((r_state == S_READ) && out_free && rw_last) begin
            cell_op = CELL_ROTATE;  // next signature's slot moves to cell 0
        end else begin
            cell_op = CELL_HOLD;
        end
    end

    // rank chain
    for (genvar c = 0; c < MAX_GROUP; c++) begin : g_cell
        gss_cell #(
            .SL_W (SL_W),
            .IDX  (c)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op),
            .i_j     (r_j),
            .i_i     (r_i),
            .i_key   (r_i),
            .i_left  ((c == 0) ? r_i : w_cell[(c + MAX_GROUP - 1) % MAX_GROUP]),
            .i_right (w_cell[(c + 1) % MAX_GROUP]),
            .o_slot  (w_cell[c])
        );
    end

    // signature store, one write and two registered read ports
    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            r_store[r_load_pos[AW-1:0]] <= s_axis_tdata;
        end
        r_rd_a <= r_store[addr_a];
        r_rd_b <= r_store[addr_b];
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_READ) && out_free) begin
            r_m_data <= r_rd_a;
            r_m_last <= rd_last;
        end
    end

    // output valid: set by a finished read, cleared by a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (!cfg_wr && (r_state == S_READ) && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_sig_words  <= SIG_WORDS_RST;
            r_group_size <= GROUP_SIZE_RST;
            r_emit       <= 1'b0;
            r_load_pos   <= '0;
            r_read_pos   <= '0;
            r_rw         <= '0;
            r_w          <= '0;
            r_i          <= '0;
            r_j          <= '0;
        end else begin
            if (cfg_wr) begin
                // a write to sig_words or group_size abandons the current group
                unique case (i_cfg_index)
                    REG_SIG_WORDS:  r_sig_words  <= i_cfg_data[SW_REG_W-1:0];
                    REG_GROUP_SIZE: r_group_size <= i_cfg_data[GS_REG_W-1:0];
                    default: ;
                endcase
                if (i_cfg_index == REG_SIG_WORDS || i_cfg_index == REG_GROUP_SIZE) begin
                    r_emit     <= 1'b0;
                    r_load_pos <= '0;
                    r_read_pos <= '0;
                    r_rw       <= '0;
                    r_state    <= S_IDLE;
                end
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (load_wr) begin
                            r_load_pos <= r_load_pos + 1'b1;
                            if (load_done) begin
                                r_emit     <= 1'b1;
                                r_read_pos <= '0;
                                r_rw       <= '0;
                                if (eff_gs != GS_W'(1)) begin
                                    r_i     <= SL_W'(1);
                                    r_j     <= SL_W'(1);
                                    r_w     <= '0;
                                    r_state <= S_CMP;
                                end
                            end
                        end else if (in_acc && (s_axis_tuser == FUNC_READ) && r_emit) begin
                            r_state <= S_READ;
                        end
                    end
                    S_CMP, S_WAIT: begin
                        if (do_insert) begin
                            if (sort_last) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_i     <= r_i + 1'b1;
                                r_j     <= r_i + 1'b1;
                                r_w     <= '0;
                                r_state <= S_CMP;
                            end
                        end else if (r_state == S_CMP) begin
                            r_state <= S_WAIT;
                        end else if (cmp_gt) begin
                            // slot at j-1 sorts after the key: move on down
                            r_j     <= r_j - 1'b1;
                            r_w     <= '0;
                            r_state <= S_CMP;
                        end else begin
                            r_w     <= r_w + 1'b1;
                            r_state <= S_CMP;
                        end
                    end
                    S_READ: begin
                        if (out_free) begin
                            // the last word of the group is also the last of its signature
                            r_read_pos <= rd_last ? '0 : r_read_pos + 1'b1;
                            r_rw       <= rw_last ? '0 : r_rw + 1'b1;
                            r_state    <= S_IDLE;
                            if (rd_last) begin
                                r_emit     <= 1'b0;
                                r_load_pos <= '0;
                            end
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

    `GSS_ASSERT_SAME(a_read_pos_idle, i_clk, i_rst_n, !r_emit, r_read_pos == '0, "read position moved while loading")
    `GSS_ASSERT_SAME(a_j_below_i, i_clk, i_rst_n, (r_state == S_CMP) || (r_state == S_WAIT), r_j <= r_i, "insert position above key")
    `GSS_ASSERT_NEXT(a_drop_load, i_clk, i_rst_n, in_acc && (s_axis_tuser == FUNC_LOAD) && r_emit && !cfg_wr, $stable(r_load_pos), "load taken during read out")
    `GSS_ASSERT_SAME(a_out_from_read, i_clk, i_rst_n, $rose(r_m_valid), $past(r_state == S_READ), "result without a read")
endmodule
`default_nettype wire

>>> design/gss_cell.sv
// one cell of the rank chain: holds one signature slot number
`default_nettype none
module gss_cell #(
    parameter int SL_W = 4,
    parameter int IDX  = 0
) (
    input  wire logic              i_clk,
    input  wire gss_pkg::t_cell_op i_op,
    input  wire logic [SL_W-1:0]   i_j,
    input  wire logic [SL_W-1:0]   i_i,
    input  wire logic [SL_W-1:0]   i_key,
    input  wire logic [SL_W-1:0]   i_left,
    input  wire logic [SL_W-1:0]   i_right,
    output logic      [SL_W-1:0]   o_slot
);
    import gss_pkg::*;

    localparam logic [SL_W-1:0] IDX_V = SL_W'(IDX);

    logic [SL_W-1:0] r_slot;

    always_ff @(posedge i_clk) begin
        case (i_op)
            CELL_INIT: r_slot <= IDX_V;
            CELL_INSERT: begin
                // key lands at j, cells above j up to i move one place up
                if (IDX_V == i_j) begin
                    r_slot <= i_key;
                end else if (IDX_V > i_j && IDX_V <= i_i) begin
                    r_slot <= i_left;
                end
            end
            CELL_ROTATE: r_slot <= i_right;
            default: r_slot <= r_slot;
        endcase
    end

    assign o_slot = r_slot;
endmodule
`default_nettype wire
